### rtl/srlc_pkg.sv
package srlc_pkg;

    localparam int ADDRESS_CHARS = 6;
    localparam int ADDR_BYTES    = ADDRESS_CHARS / 2;
    localparam int ADDR_W        = 24;
    localparam int POS_W         = 10;
    localparam int Q_W           = POS_W - 1;
    localparam int DIFF_W        = POS_W + 2;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = FIFO_PTR_W + 1;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [7:0] CHAR_S    = 8'h53;
    localparam logic [7:0] CHAR_CR   = 8'h0d;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_1    = 8'h31;
    localparam logic [7:0] CHAR_2    = 8'h32;
    localparam logic [7:0] CHAR_3    = 8'h33;
    localparam logic [7:0] CHAR_9    = 8'h39;
    localparam logic [7:0] CHAR_UA   = 8'h41;
    localparam logic [7:0] CHAR_UF   = 8'h46;
    localparam logic [7:0] CHAR_LA   = 8'h61;
    localparam logic [7:0] CHAR_LF   = 8'h66;
    localparam logic [7:0] HEX_TEN   = 8'd10;

    localparam logic [2:0] KIND_NONE      = 3'd0;
    localparam logic [2:0] KIND_BADSTART  = 3'd1;
    localparam logic [2:0] KIND_S0        = 3'd2;
    localparam logic [2:0] KIND_UNHANDLED = 3'd3;
    localparam logic [2:0] KIND_S2        = 3'd4;
    localparam logic [2:0] KIND_UNKNOWN   = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BADSUM    = 3'd1;
    localparam logic [2:0] ST_LONG      = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_BADSTART  = 3'd4;
    localparam logic [2:0] ST_UNHANDLED = 3'd5;
    localparam logic [2:0] ST_VENDOR    = 3'd6;
    localparam logic [2:0] ST_UNKNOWN   = 3'd7;

    typedef struct packed {
        logic              is_status;
        logic              last_of_run;
        logic [ADDR_W-1:0] byte_address;
        logic [7:0]        data_byte;
        logic [2:0]        line_status;
        logic [7:0]        computed_sum;
    } result_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            v = c - CHAR_0;
        end
        else if (c >= CHAR_UA && c <= CHAR_UF)
        begin
            v = c - CHAR_UA + HEX_TEN;
        end
        else if (c >= CHAR_LA && c <= CHAR_LF)
        begin
            v = c - CHAR_LA + HEX_TEN;
        end
        return v[3:0];
    endfunction

endpackage

### rtl/srecord_s2_line_checker_core.sv
// S2 line checker: takes one character of a Motorola S-record line per word, with
// line_end high on the line's last character. Each decoded data byte of an S2 line
// leaves as a data word with its 24-bit address; the line's last character also
// yields a status word (ok, bad checksum, too long, too short, bad start, S1/S3
// unhandled, S0 vendor, unknown type) carrying the start address and computed
// checksum of S2 lines. A character is taken every cycle while char_ready is high;
// decoding is one level of logic from the held line state into a four-entry result
// queue, and char_ready stays high as long as the queue has room for two results.
// Only a line-end character that also completes a data byte makes two results.
module srecord_s2_line_checker_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         char_valid,
    output logic                         char_ready,
    input  logic [7:0]                   char_code,
    input  logic                         line_end,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic                         is_status,
    output logic                         last_of_run,
    output logic [srlc_pkg::ADDR_W-1:0]  byte_address,
    output logic [7:0]                   data_byte,
    output logic [2:0]                   line_status,
    output logic [7:0]                   computed_sum
);

    logic [srlc_pkg::POS_W-1:0]  char_position_reg, char_position_next;
    logic [2:0]                  record_kind_reg, record_kind_next;
    logic [7:0]                  pair_count_reg, pair_count_next;
    logic [7:0]                  running_sum_reg, running_sum_next;
    logic [srlc_pkg::ADDR_W-1:0] start_address_reg, start_address_next;
    logic [3:0]                  high_nibble_reg, high_nibble_next;
    logic [7:0]                  received_sum_reg, received_sum_next;
    logic [7:0]                  data_index_reg, data_index_next;

    srlc_pkg::result_t               fifo_reg [srlc_pkg::FIFO_DEPTH];
    logic [srlc_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [srlc_pkg::FIFO_CNT_W-1:0] count_reg;

    logic                        accept, pop;
    logic [srlc_pkg::POS_W-1:0]  off;
    logic [srlc_pkg::Q_W-1:0]    q;
    logic [7:0]                  pair_byte;
    logic                        roomy;
    logic                        data_push;
    logic [7:0]                  sum_calc;
    logic signed [srlc_pkg::DIFF_W-1:0] diff;
    logic                        too_long, too_short;
    logic [2:0]                  status_code;
    srlc_pkg::result_t           data_item, status_item, entry0, entry1;
    logic [1:0]                  push_n;

    assign accept = char_valid && char_ready;
    assign pop    = result_valid && result_ready;
    assign char_ready = count_reg <= srlc_pkg::FIFO_CNT_W'(srlc_pkg::FIFO_DEPTH - 2);
    assign result_valid = count_reg != '0;

    assign off       = char_position_reg - srlc_pkg::POS_W'(2);
    assign q         = off[srlc_pkg::POS_W-1:1];
    assign pair_byte = {high_nibble_reg, srlc_pkg::hex_value(char_code)};
    assign roomy     = pair_count_reg >= 8'(srlc_pkg::ADDR_BYTES + 1);

    always_comb
    begin
        record_kind_next   = record_kind_reg;
        pair_count_next    = pair_count_reg;
        running_sum_next   = running_sum_reg;
        start_address_next = start_address_reg;
        high_nibble_next   = high_nibble_reg;
        received_sum_next  = received_sum_reg;
        data_index_next    = data_index_reg;
        data_push          = 1'b0;
        char_position_next = char_position_reg;
        if (char_position_reg != srlc_pkg::POS_MAX)
        begin
            char_position_next = char_position_reg + srlc_pkg::POS_W'(1);
        end

        if (char_position_reg == '0)
        begin
            record_kind_next = (char_code == srlc_pkg::CHAR_S) ?
                               srlc_pkg::KIND_NONE : srlc_pkg::KIND_BADSTART;
        end
        else if (char_position_reg == srlc_pkg::POS_W'(1))
        begin
            if (record_kind_reg == srlc_pkg::KIND_NONE)
            begin
                if (char_code == srlc_pkg::CHAR_0)
                begin
                    record_kind_next = srlc_pkg::KIND_S0;
                end
                else if (char_code == srlc_pkg::CHAR_1 || char_code == srlc_pkg::CHAR_3)
                begin
                    record_kind_next = srlc_pkg::KIND_UNHANDLED;
                end
                else if (char_code == srlc_pkg::CHAR_2)
                begin
                    record_kind_next = srlc_pkg::KIND_S2;
                end
                else
                begin
                    record_kind_next = srlc_pkg::KIND_UNKNOWN;
                end
            end
        end
        else if (record_kind_reg == srlc_pkg::KIND_S2)
        begin
            if (!off[0])
            begin
                high_nibble_next = srlc_pkg::hex_value(char_code);
            end
            else if (q == '0)
            begin
                pair_count_next  = pair_byte;
                running_sum_next = running_sum_reg + pair_byte;
            end
            else if (q <= srlc_pkg::Q_W'(srlc_pkg::ADDR_BYTES))
            begin
                start_address_next = {start_address_reg[srlc_pkg::ADDR_W-9:0], pair_byte};
                running_sum_next   = running_sum_reg + pair_byte;
            end
            else if (roomy && q < srlc_pkg::Q_W'(pair_count_reg))
            begin
                data_push        = 1'b1;
                running_sum_next = running_sum_reg + pair_byte;
                data_index_next  = data_index_reg + 8'd1;
            end
            else if (roomy && q == srlc_pkg::Q_W'(pair_count_reg))
            begin
                received_sum_next = pair_byte;
            end
        end
    end

    // end-of-line status from the updated line state
    always_comb
    begin
        sum_calc  = ~running_sum_next;
        diff      = $signed({2'b00, char_position_reg}) - srlc_pkg::DIFF_W'(3)
                    - $signed({3'b000, pair_count_next, 1'b0});
        too_long  = (diff > srlc_pkg::DIFF_W'(1)) ||
                    (diff == srlc_pkg::DIFF_W'(1) && char_code != srlc_pkg::CHAR_CR);
        too_short = (diff < 0) || (pair_count_next < 8'(srlc_pkg::ADDR_BYTES + 1));
        unique case (record_kind_next)
            srlc_pkg::KIND_BADSTART:  status_code = srlc_pkg::ST_BADSTART;
            srlc_pkg::KIND_S0:        status_code = srlc_pkg::ST_VENDOR;
            srlc_pkg::KIND_UNHANDLED: status_code = srlc_pkg::ST_UNHANDLED;
            srlc_pkg::KIND_S2:
            begin
                if (too_long)
                begin
                    status_code = srlc_pkg::ST_LONG;
                end
                else if (too_short)
                begin
                    status_code = srlc_pkg::ST_SHORT;
                end
                else if (received_sum_next != sum_calc)
                begin
                    status_code = srlc_pkg::ST_BADSUM;
                end
                else
                begin
                    status_code = srlc_pkg::ST_OK;
                end
            end
            default:                  status_code = srlc_pkg::ST_UNKNOWN;
        endcase

        status_item.is_status    = 1'b1;
        status_item.last_of_run  = 1'b1;
        status_item.data_byte    = 8'd0;
        status_item.line_status  = status_code;
        if (record_kind_next == srlc_pkg::KIND_S2)
        begin
            status_item.byte_address = start_address_next;
            status_item.computed_sum = sum_calc;
        end
        else
        begin
            status_item.byte_address = '0;
            status_item.computed_sum = 8'd0;
        end

        data_item.is_status    = 1'b0;
        data_item.last_of_run  = !line_end;
        data_item.byte_address = start_address_reg + srlc_pkg::ADDR_W'(data_index_reg);
        data_item.data_byte    = pair_byte;
        data_item.line_status  = srlc_pkg::ST_OK;
        data_item.computed_sum = 8'd0;

        entry0 = data_push ? data_item : status_item;
        entry1 = status_item;
        push_n = accept ? (2'(data_push) + 2'(line_end)) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_position_reg <= '0;
            record_kind_reg   <= srlc_pkg::KIND_NONE;
            pair_count_reg    <= 8'd0;
            running_sum_reg   <= 8'd0;
            start_address_reg <= '0;
            high_nibble_reg   <= 4'd0;
            received_sum_reg  <= 8'd0;
            data_index_reg    <= 8'd0;
        end
        else if (accept)
        begin
            if (line_end)
            begin
                char_position_reg <= '0;
                record_kind_reg   <= srlc_pkg::KIND_NONE;
                pair_count_reg    <= 8'd0;
                running_sum_reg   <= 8'd0;
                start_address_reg <= '0;
                high_nibble_reg   <= 4'd0;
                received_sum_reg  <= 8'd0;
                data_index_reg    <= 8'd0;
            end
            else
            begin
                char_position_reg <= char_position_next;
                record_kind_reg   <= record_kind_next;
                pair_count_reg    <= pair_count_next;
                running_sum_reg   <= running_sum_next;
                start_address_reg <= start_address_next;
                high_nibble_reg   <= high_nibble_next;
                received_sum_reg  <= received_sum_next;
                data_index_reg    <= data_index_next;
            end
        end
    end

    // result queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + srlc_pkg::FIFO_PTR_W'(push_n);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + srlc_pkg::FIFO_PTR_W'(1);
            end
            count_reg <= count_reg + srlc_pkg::FIFO_CNT_W'(push_n)
                         - srlc_pkg::FIFO_CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= entry0;
        end
        if (push_n == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + srlc_pkg::FIFO_PTR_W'(1)] <= entry1;
        end
    end

    assign is_status    = fifo_reg[rd_ptr_reg].is_status;
    assign last_of_run  = fifo_reg[rd_ptr_reg].last_of_run;
    assign byte_address = fifo_reg[rd_ptr_reg].byte_address;
    assign data_byte    = fifo_reg[rd_ptr_reg].data_byte;
    assign line_status  = fifo_reg[rd_ptr_reg].line_status;
    assign computed_sum = fifo_reg[rd_ptr_reg].computed_sum;

endmodule

### rtl/srlc_checker.sv
module srlc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         char_valid,
    input logic                         char_ready,
    input logic [7:0]                   char_code,
    input logic                         line_end,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic                         is_status,
    input logic                         last_of_run,
    input logic [srlc_pkg::ADDR_W-1:0]  byte_address,
    input logic [7:0]                   data_byte,
    input logic [2:0]                   line_status,
    input logic [7:0]                   computed_sum
);

    // waiting input word holds
    a_char_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_ready |=> char_valid && $stable(char_code)
        && $stable(line_end))
    else $error("waiting input word changed");

    // stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(is_status)
        && $stable(byte_address) && $stable(data_byte) && $stable(line_status))
    else $error("stalled result word changed");

    // data words carry no status or checksum
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !is_status |-> line_status == srlc_pkg::ST_OK
        && computed_sum == 8'd0)
    else $error("data word with status fields");

    // status word closes the run of its character
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && is_status |-> last_of_run && data_byte == 8'd0)
    else $error("status word not last or has data");

    // non-S2 lines report no address or checksum
    a_non_s2_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && is_status && (line_status == srlc_pkg::ST_BADSTART
        || line_status == srlc_pkg::ST_UNHANDLED || line_status == srlc_pkg::ST_VENDOR
        || line_status == srlc_pkg::ST_UNKNOWN)
        |-> byte_address == '0 && computed_sum == 8'd0)
    else $error("non-S2 status with address or checksum");

endmodule

bind srecord_s2_line_checker_core srlc_checker u_srlc_checker (.*);
